// ----- sv/ess_pkg.sv -----
// shared types, codes and reset values for the exercise servo sequencer
`default_nettype none
package ess_pkg;

	localparam int FILTER_DEPTH_DEF = 5;
	localparam int MS_PER_SECOND = 1000;

	localparam int ANGLE_W = 8;
	localparam int LEVEL_W = 12;
	localparam int PHASE_W = 18;
	localparam int SINCE_W = 26;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [ANGLE_W-1:0] REST_ANGLE_RST = 8'd5;
	localparam logic [ANGLE_W-1:0] LEVEL_ONE_RST = 8'd35;
	localparam logic [ANGLE_W-1:0] LEVEL_TWO_RST = 8'd50;
	localparam logic [ANGLE_W-1:0] LEVEL_THREE_RST = 8'd75;
	localparam logic [ANGLE_W-1:0] EMG_ANGLE_RST = 8'd73;
	localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 12'd10;
	localparam logic [LEVEL_W-1:0] HOLDOFF_RST = 12'd2000;

	typedef enum logic [1:0] {
		ITEM_TICK = 2'd0,
		ITEM_SAMPLE = 2'd1,
		ITEM_CMD = 2'd2,
		ITEM_NOP = 2'd3
	} item_kind_t;

	typedef enum logic [2:0] {
		EX_STANDBY = 3'd0,
		EX_LEVEL1 = 3'd1,
		EX_LEVEL2 = 3'd2,
		EX_LEVEL3 = 3'd3,
		EX_EMG = 3'd4
	} exercise_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REST_ANGLE = 3'd0,
		REG_LEVEL_ONE = 3'd1,
		REG_LEVEL_TWO = 3'd2,
		REG_LEVEL_THREE = 3'd3,
		REG_EMG_ANGLE = 3'd4,
		REG_THRESHOLD = 3'd5,
		REG_HOLDOFF = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] rest_angle;
		logic [ANGLE_W-1:0] angle_level_one;
		logic [ANGLE_W-1:0] angle_level_two;
		logic [ANGLE_W-1:0] angle_level_three;
		logic [ANGLE_W-1:0] emg_active_angle;
		logic [LEVEL_W-1:0] emg_threshold;
		logic [LEVEL_W-1:0] holdoff_ms;
	} cfg_t;

	typedef struct packed {
		item_kind_t kind;
		logic [LEVEL_W-1:0] emg_sample;
		logic [2:0] cmd_exercise;
		logic cmd_has_times;
		logic [7:0] cmd_interval_s;
		logic [15:0] cmd_series_s;
	} item_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] servo_angle;
		logic [2:0] exercise_now;
		logic series_done;
		logic [LEVEL_W-1:0] emg_level;
	} result_t;

endpackage
`default_nettype wire

// ----- sv/ess_cfg_regs.sv -----
// configuration register file, written through the cfg channel
`default_nettype none
module ess_cfg_regs (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire logic [ess_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [ess_pkg::CFG_DATA_W-1:0] wr_data,
	output ess_pkg::cfg_t cfg
);
	import ess_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_angle <= REST_ANGLE_RST;
			cfg_q.angle_level_one <= LEVEL_ONE_RST;
			cfg_q.angle_level_two <= LEVEL_TWO_RST;
			cfg_q.angle_level_three <= LEVEL_THREE_RST;
			cfg_q.emg_active_angle <= EMG_ANGLE_RST;
			cfg_q.emg_threshold <= THRESHOLD_RST;
			cfg_q.holdoff_ms <= HOLDOFF_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				REG_REST_ANGLE: cfg_q.rest_angle <= wr_data[ANGLE_W-1:0];
				REG_LEVEL_ONE: cfg_q.angle_level_one <= wr_data[ANGLE_W-1:0];
				REG_LEVEL_TWO: cfg_q.angle_level_two <= wr_data[ANGLE_W-1:0];
				REG_LEVEL_THREE: cfg_q.angle_level_three <= wr_data[ANGLE_W-1:0];
				REG_EMG_ANGLE: cfg_q.emg_active_angle <= wr_data[ANGLE_W-1:0];
				REG_THRESHOLD: cfg_q.emg_threshold <= wr_data[LEVEL_W-1:0];
				REG_HOLDOFF: cfg_q.holdoff_ms <= wr_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- sv/ess_core.sv -----
// sequencer state and combinational next-state logic for one item
`default_nettype none
module ess_core #(
	parameter int FILTER_DEPTH = ess_pkg::FILTER_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire ess_pkg::item_t item,
	input  wire ess_pkg::cfg_t cfg,
	output ess_pkg::result_t res
);
	import ess_pkg::*;

	localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
	localparam logic [LEVEL_W:0] CEIL_BIAS = (LEVEL_W+1)'(FILTER_DEPTH - 1);
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W = LEVEL_W + RECIP_SHIFT + 2;
	// rounded-up reciprocal of the depth, exact for every dividend seen here
	localparam logic [PROD_W-1:0] RECIP =
		PROD_W'(((1 << RECIP_SHIFT) + FILTER_DEPTH - 1) / FILTER_DEPTH);

	exercise_t mode_q, mode_d;
	logic active_q, active_d;
	logic [PHASE_W-1:0] phase_q, phase_d, phase_inc;
	logic [PHASE_W-1:0] interval_q, interval_d;
	logic [SINCE_W-1:0] series_ms_q, series_ms_d;
	logic [SINCE_W-1:0] since_q, since_d, since_inc;
	logic [LEVEL_W-1:0] level_q, level_d, level_new;
	logic [LEVEL_W-1:0] level_ceil, sample_div;
	logic [PROD_W-1:0] ceil_prod, sample_prod;
	logic toggle_q, toggle_d;
	logic [LEVEL_W-1:0] holdoff_q, holdoff_d;
	logic [ANGLE_W-1:0] angle_q, angle_d, level_angle;
	logic done;

	// floor(f*(n-1)/n) = f - ceil(f/n), both divisions by a constant
	assign ceil_prod = PROD_W'({1'b0, level_q} + CEIL_BIAS) * RECIP;
	assign level_ceil = ceil_prod[RECIP_SHIFT +: LEVEL_W];
	assign sample_prod = PROD_W'(item.emg_sample) * RECIP;
	assign sample_div = sample_prod[RECIP_SHIFT +: LEVEL_W];
	assign level_new = LEVEL_W'({1'b0, level_q} - {1'b0, level_ceil} + {1'b0, sample_div});

	assign phase_inc = phase_q + PHASE_W'(1);
	assign since_inc = (since_q == SINCE_MAX) ? since_q : since_q + SINCE_W'(1);

	always_comb begin
		case (mode_q)
			EX_LEVEL1: level_angle = cfg.angle_level_one;
			EX_LEVEL2: level_angle = cfg.angle_level_two;
			default: level_angle = cfg.angle_level_three;
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		active_d = active_q;
		phase_d = phase_q;
		interval_d = interval_q;
		series_ms_d = series_ms_q;
		since_d = since_q;
		level_d = level_q;
		toggle_d = toggle_q;
		holdoff_d = holdoff_q;
		angle_d = angle_q;
		done = 1'b0;
		unique case (item.kind)
			ITEM_TICK: begin
				if (holdoff_q != '0) holdoff_d = holdoff_q - LEVEL_W'(1);
				if (mode_q == EX_STANDBY) begin
					angle_d = cfg.rest_angle;
					since_d = '0;
				end else begin
					since_d = since_inc;
					if (mode_q != EX_EMG) begin
						if (phase_inc >= interval_q) begin
							phase_d = '0;
							if (!active_q) begin
								active_d = 1'b1;
								angle_d = level_angle;
							end else begin
								active_d = 1'b0;
								angle_d = cfg.rest_angle;
								// end of a full cycle: series over?
								if (since_inc >= series_ms_q) begin
									mode_d = EX_STANDBY;
									since_d = '0;
									done = 1'b1;
								end
							end
						end else begin
							phase_d = phase_inc;
						end
					end
				end
			end
			ITEM_SAMPLE: begin
				if (mode_q == EX_EMG && holdoff_q == '0) begin
					level_d = level_new;
					if (level_new >= cfg.emg_threshold) begin
						angle_d = toggle_q ? cfg.rest_angle : cfg.emg_active_angle;
						toggle_d = ~toggle_q;
						holdoff_d = cfg.holdoff_ms;
					end
				end
			end
			ITEM_CMD: begin
				if (item.cmd_exercise <= EX_EMG) begin
					mode_d = exercise_t'(item.cmd_exercise);
					active_d = 1'b0;
					phase_d = '0;
					if (item.cmd_exercise != EX_EMG) angle_d = cfg.rest_angle;
					if (item.cmd_exercise == EX_STANDBY) since_d = '0;
				end
				if (item.cmd_has_times) begin
					interval_d = PHASE_W'(item.cmd_interval_s) * PHASE_W'(MS_PER_SECOND);
					series_ms_d = SINCE_W'(item.cmd_series_s) * SINCE_W'(MS_PER_SECOND);
				end
			end
			ITEM_NOP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= EX_STANDBY;
			active_q <= 1'b0;
			phase_q <= '0;
			interval_q <= '0;
			series_ms_q <= '0;
			since_q <= '0;
			level_q <= '0;
			toggle_q <= 1'b0;
			holdoff_q <= '0;
			angle_q <= REST_ANGLE_RST;
		end else if (adv) begin
			mode_q <= mode_d;
			active_q <= active_d;
			phase_q <= phase_d;
			interval_q <= interval_d;
			series_ms_q <= series_ms_d;
			since_q <= since_d;
			level_q <= level_d;
			toggle_q <= toggle_d;
			holdoff_q <= holdoff_d;
			angle_q <= angle_d;
		end
	end

	assign res.servo_angle = angle_d;
	assign res.exercise_now = mode_d;
	assign res.series_done = done;
	assign res.emg_level = level_d;

endmodule
`default_nettype wire

// ----- sv/exercise_servo_sequencer.sv -----
// exercise servo sequencer: usage
// Items arrive on in_valid/in_ready: mode selects a 1 ms tick, an EMG sample,
// a command or a no-op; the other fields are the sample and command payload.
// Every accepted item yields exactly one result on out_valid/out_ready with
// the commanded servo angle, the current exercise mode, a series-done flag
// and the filtered EMG level.
// An accepted item is held in the input register, processed against the
// sequencer state, and its result is loaded into the result register
// once the output is free.
// Throughput: one item per cycle while the receiver accepts results; the
// whole update is one pass of logic between the input and result registers.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready stays high) and should only be made while no item is in flight.
// Reset sets config and state to defaults: standby mode, rest angle 5.
// When the receiver stalls the result register holds; the input register
// holds too and in_ready drops once both are full.
`default_nettype none
module exercise_servo_sequencer #(
	parameter int FILTER_DEPTH = ess_pkg::FILTER_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] mode,
	input  wire logic [11:0] emg_sample,
	input  wire logic [2:0] cmd_exercise,
	input  wire logic cmd_has_times,
	input  wire logic [7:0] cmd_interval_s,
	input  wire logic [15:0] cmd_series_s,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [7:0] servo_angle,
	output logic [2:0] exercise_now,
	output logic series_done,
	output logic [11:0] emg_level,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [11:0] cfg_data
);
	import ess_pkg::*;

	logic valid_s1;
	item_t item_s1;
	logic adv;
	logic out_valid_q;
	result_t res, res_q;
	cfg_t cfg;

	assign cfg_ready = 1'b1;

	ess_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	// item in the input register moves on when the result register is free
	assign adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind <= item_kind_t'(mode);
			item_s1.emg_sample <= emg_sample;
			item_s1.cmd_exercise <= cmd_exercise;
			item_s1.cmd_has_times <= cmd_has_times;
			item_s1.cmd_interval_s <= cmd_interval_s;
			item_s1.cmd_series_s <= cmd_series_s;
		end
	end

	ess_core #(
		.FILTER_DEPTH(FILTER_DEPTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.item(item_s1),
		.cfg(cfg),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign servo_angle = res_q.servo_angle;
	assign exercise_now = res_q.exercise_now;
	assign series_done = res_q.series_done;
	assign emg_level = res_q.emg_level;

endmodule
`default_nettype wire

// ----- sv/ess_checker.sv -----
// port-level checker for the exercise servo sequencer, bound to the top level
`default_nettype none
module ess_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] servo_angle,
	input wire logic [2:0] exercise_now,
	input wire logic series_done,
	input wire logic [11:0] emg_level
);
	import ess_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(servo_angle)
		&& $stable(exercise_now) && $stable(series_done) && $stable(emg_level))
		else $error("result changed while stalled");

	// a finished series always reports standby
	a_done_standby: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && series_done |-> exercise_now == EX_STANDBY)
		else $error("series done without standby");

	// input backpressure only while the output stalls (both registers are then full)
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// a transfer passes through the input and result registers to the output when the receiver is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("result missing after transfer");

endmodule

bind exercise_servo_sequencer ess_checker u_ess_checker (.*);
`default_nettype wire
